@@ src/cost_curve_interpolation_assert.svh @@
// Assertion macros for the cost curve interpolation block.
// Used by the port checker; needs no package.
`ifndef COST_CURVE_INTERPOLATION_ASSERT_SVH
`define COST_CURVE_INTERPOLATION_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define CCI_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication: when the antecedent holds, the consequent holds in the same cycle.
`define CCI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication: when the antecedent holds, the consequent holds in the next cycle.
`define CCI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/cci_pkg.sv @@
// Shared constants, opcodes and controller/datapath interface types
// for the cost curve interpolation block. No dependencies.
package cci_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 256;
	localparam int COST_W = 32;
	localparam int FRAC_W = 17;
	localparam int PROD_W = COST_W + FRAC_W;

	localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_CLEAR  = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic append;
		logic clear;
		logic load_q;
		logic rd_first;
		logic shift;
		logic capture;
		logic mul;
		logic div_start;
		logic finish;
		logic set_miss;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic few_points;
		logic hit;
		logic last;
		logic zero_width;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

@@ src/cost_curve_interpolation.sv @@
// Top level of the cost curve interpolation block.
// Depends on cci_pkg, cci_ctrl and cci_datapath.
//
// Usage: the input channel (in_valid/in_ready) carries one item per transfer:
// opcode append stores point_cost/point_fraction as the next curve point
// (ignored once TABLE_DEPTH points are held), opcode clear empties the table,
// and opcode query looks up point_cost on the curve. Only a query produces a
// result on the output channel (out_valid/out_ready): found and
// remaining_fraction, which is one minus the interpolated fraction in Q1.16.
// A query scans the stored segments one per cycle through the single read port
// of the point tables, then passes through the multiplier and, unless the
// bracketing segment has zero width, the bit-serial divider; when no segment
// brackets the cost, the query ends after the scan with found low. Items are
// taken one at a time.
// The result sits in an output register; the next item is accepted while it
// waits, and only a later query result waits on a stalled receiver.
// Reset empties the table and drops any pending result; no clearing pass runs.
module cost_curve_interpolation
	import cci_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        opcode,
	input  logic [COST_W-1:0] point_cost,
	input  logic [FRAC_W-1:0] point_fraction,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              found,
	output logic [FRAC_W-1:0] remaining_fraction
);

	cmd_t cmd;
	sts_t sts;

	// The controller owns sequencing; the datapath holds all table and
	// arithmetic state and reports segment match, scan end and divider done.
	cci_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.sts      (sts),
		.cmd      (cmd)
	);

	cci_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.point_cost         (point_cost),
		.point_fraction     (point_fraction),
		.out_ready          (out_ready),
		.out_valid          (out_valid),
		.found              (found),
		.remaining_fraction (remaining_fraction)
	);

endmodule

@@ src/cci_div.sv @@
// Restoring divider, one quotient bit per cycle, for the interpolation step.
// Depends on cci_pkg for the operand widths.
module cci_div
	import cci_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [COST_W-1:0] divisor,
	output logic              done,
	output logic [PROD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(PROD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [COST_W-1:0] rem_q;
	logic [COST_W-1:0] dsr_q;
	logic [PROD_W-1:0] num_q;

	logic [COST_W:0] rem_sh;
	logic [COST_W:0] rem_sub;
	logic            ge;

	assign rem_sh  = {rem_q, num_q[PROD_W-1]};
	assign ge      = rem_sh >= {1'b0, dsr_q};
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(PROD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			num_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[COST_W-1:0] : rem_sh[COST_W-1:0];
			num_q <= {num_q[PROD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

@@ src/cci_datapath.sv @@
// Datapath: point tables, segment scan registers, multiplier, divider and
// output register. Depends on cci_pkg and cci_div.
module cci_datapath
	import cci_pkg::*;
#(
	parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [COST_W-1:0] point_cost,
	input  logic [FRAC_W-1:0] point_fraction,
	input  logic              out_ready,
	output logic              out_valid,
	output logic              found,
	output logic [FRAC_W-1:0] remaining_fraction
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [COST_W-1:0] cost_mem [TABLE_DEPTH];
	logic [FRAC_W-1:0] frac_mem [TABLE_DEPTH];

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic [COST_W-1:0] q_q;
	logic [COST_W-1:0] rd_cost_q;
	logic [FRAC_W-1:0] rd_frac_q;
	logic [COST_W-1:0] prev_cost_q;
	logic [FRAC_W-1:0] prev_frac_q;
	logic [COST_W-1:0] diff_q;
	logic [COST_W-1:0] den_q;
	logic [FRAC_W-1:0] mag_q;
	logic [FRAC_W-1:0] f2_q;
	logic              neg_q;
	logic              zw_q;
	logic [PROD_W-1:0] prod_q;
	logic              res_found_q;
	logic [FRAC_W-1:0] res_frac_q;
	logic              out_valid_q;
	logic              found_q;
	logic [FRAC_W-1:0] remaining_q;

	logic              full;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              div_done;
	logic [PROD_W-1:0] quot;
	logic [FRAC_W:0]   sum_c;
	logic [FRAC_W:0]   f_c;

	assign full    = count_q == CW'(TABLE_DEPTH);
	assign rd_en   = cmd.rd_first | cmd.shift;
	assign rd_addr = cmd.rd_first ? '0 : idx_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.append && !full) begin
			cost_mem[count_q[AW-1:0]] <= point_cost;
			frac_mem[count_q[AW-1:0]] <= point_fraction;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_cost_q <= cost_mem[rd_addr];
			rd_frac_q <= frac_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.append && !full) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.rd_first) begin
				idx_q <= CW'(1);
			end else if (cmd.shift) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// The previous entry pairs with the freshly read one to form a segment.
	always_ff @(posedge clk) begin
		if (cmd.load_q) begin
			q_q <= point_cost;
		end
		if (cmd.shift) begin
			prev_cost_q <= rd_cost_q;
			prev_frac_q <= rd_frac_q;
		end
		if (cmd.capture) begin
			diff_q <= q_q - rd_cost_q;
			den_q  <= prev_cost_q - rd_cost_q;
			zw_q   <= prev_cost_q == rd_cost_q;
			f2_q   <= rd_frac_q;
			neg_q  <= rd_frac_q < prev_frac_q;
			mag_q  <= (rd_frac_q < prev_frac_q) ? prev_frac_q - rd_frac_q
			                                    : rd_frac_q - prev_frac_q;
		end
		if (cmd.mul) begin
			prod_q <= diff_q * mag_q;
		end
	end

	cci_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (den_q),
		.done     (div_done),
		.quotient (quot)
	);

	// Interpolated fraction, saturated to the range zero to one.
	assign sum_c = {1'b0, f2_q} + {1'b0, quot[FRAC_W-1:0]};

	always_comb begin
		if (zw_q) begin
			f_c = {1'b0, f2_q};
		end else if (!neg_q) begin
			f_c = (quot > PROD_W'(f2_q)) ? '0 : {1'b0, f2_q - quot[FRAC_W-1:0]};
		end else begin
			f_c = (|quot[PROD_W-1:FRAC_W]) ? {1'b0, ONE_Q16} : sum_c;
		end
		if (f_c > {1'b0, ONE_Q16}) begin
			f_c = {1'b0, ONE_Q16};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_miss) begin
			res_found_q <= 1'b0;
			res_frac_q  <= '0;
		end else if (cmd.finish) begin
			res_found_q <= 1'b1;
			res_frac_q  <= ONE_Q16 - f_c[FRAC_W-1:0];
		end
		if (cmd.out_load) begin
			found_q     <= res_found_q;
			remaining_q <= res_frac_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.few_points = count_q < CW'(2);
	assign sts.hit        = (prev_cost_q >= q_q) && (rd_cost_q <= q_q);
	assign sts.last       = idx_q == count_q;
	assign sts.zero_width = zw_q;
	assign sts.div_done   = div_done;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid          = out_valid_q;
	assign found              = found_q;
	assign remaining_fraction = remaining_q;

endmodule

@@ src/cci_ctrl.sv @@
// Controller state machine: sequences append, clear and query items.
// Depends on cci_pkg for opcodes and the command and status structs.
module cci_ctrl
	import cci_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  sts_t       sts,
	output cmd_t       cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PRIME = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_DIVST = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       accept;

	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (opcode)
						OP_APPEND: cmd.append = 1'b1;
						OP_CLEAR:  cmd.clear = 1'b1;
						OP_QUERY: begin
							cmd.load_q = 1'b1;
							if (sts.few_points) begin
								cmd.set_miss = 1'b1;
								state_nx     = S_DONE;
							end else begin
								cmd.rd_first = 1'b1;
								state_nx     = S_PRIME;
							end
						end
						default: ;
					endcase
				end
			end
			S_PRIME: begin
				cmd.shift = 1'b1;
				state_nx  = S_SCAN;
			end
			S_SCAN: begin
				if (sts.hit) begin
					cmd.capture = 1'b1;
					state_nx    = S_MUL;
				end else if (sts.last) begin
					cmd.set_miss = 1'b1;
					state_nx     = S_DONE;
				end else begin
					cmd.shift = 1'b1;
				end
			end
			S_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = sts.zero_width ? S_FIN : S_DIVST;
			end
			S_DIVST: begin
				cmd.div_start = 1'b1;
				state_nx      = S_DIV;
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_nx = S_FIN;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_nx   = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

@@ src/cci_checker.sv @@
// Port-level checker for the cost curve interpolation block, bound to the top.
// Depends on cci_pkg and cost_curve_interpolation_assert.svh.
`include "cost_curve_interpolation_assert.svh"

module cci_checker
	import cci_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [1:0]        opcode,
	input logic              out_valid,
	input logic              out_ready,
	input logic              found,
	input logic [FRAC_W-1:0] remaining_fraction
);

	// A stalled result keeps its value.
	`CCI_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(found) && $stable(remaining_fraction), "result changed while stalled")

	// A not-found result carries a zero fraction.
	`CCI_ASSERT_IMPL(a_miss_zero, clk, arst_n, out_valid && !found, remaining_fraction == '0, "not-found result with nonzero fraction")

	// The remaining fraction never exceeds one.
	`CCI_ASSERT(a_frac_range, clk, arst_n, !out_valid || remaining_fraction <= ONE_Q16, "remaining fraction above one")

	// A query occupies the block, so the next cycle takes no item.
	`CCI_ASSERT_NEXT(a_query_busy, clk, arst_n, in_valid && in_ready && opcode == OP_QUERY, !in_ready, "item accepted right after a query")

endmodule

bind cost_curve_interpolation cci_checker u_cci_checker (.*);
